// ===== rtl/ssd_pkg.sv =====
// Shared constants and control/status types for the sample set statistics block.
`default_nettype none
package ssd_pkg;

	// set capacity and derived widths
	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SAMPLE_W    = 16;
	localparam int OUT_CNT_W   = 11;
	localparam int SUM_W       = SAMPLE_W + CNT_W;      // signed running sum
	localparam int SQ_W        = 2 * SAMPLE_W - 1;      // one square, unsigned
	localparam int SQSUM_W     = 2 * SAMPLE_W - 2 + CNT_W;
	localparam int MEAN_W      = SAMPLE_W + 1;          // signed mean incl. +32768 magnitude
	localparam int MS_W        = MEAN_W + SUM_W;        // mean * sum, signed
	localparam int MM_W        = 2 * SAMPLE_W - 1;      // mean^2, unsigned
	localparam int NMM_W       = CNT_W + MM_W;          // n * mean^2, unsigned
	localparam int IW          = 2 * SAMPLE_W + 1 + CNT_W; // signed deviation workspace
	localparam int DEV_W       = 2 * SAMPLE_W + CNT_W;  // deviation sum, unsigned
	localparam int RAD_W       = 2 * SAMPLE_W;          // variance fed to the root
	localparam int ROOT_W      = SAMPLE_W;
	localparam int DIV_CNT_W   = $clog2(DEV_W + 1);
	localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_sel_var;
		logic mean_load;
		logic mul1_load;
		logic mul2_load;
		logic dev_load;
		logic sqrt_start;
		logic out_load;
	} ssd_cmd_t;

	// status from the datapath back to the controller
	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic sqrt_done;
		logic sqrt_busy;
	} ssd_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ssd_in_if.sv =====
// Sample input channel: valid/ready with one sample and its last flag.
`default_nettype none
interface ssd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssd_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source (output valid, sample, last_sample, input ready);
	modport sink   (input valid, sample, last_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssd_out_if.sv =====
// Result output channel: valid/ready with the statistics of one set.
`default_nettype none
interface ssd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [ssd_pkg::ROOT_W-1:0]           std_dev;
	logic signed [ssd_pkg::SAMPLE_W-1:0]  mean_value;
	logic signed [ssd_pkg::SAMPLE_W-1:0]  minimum;
	logic signed [ssd_pkg::SAMPLE_W-1:0]  maximum;
	logic [ssd_pkg::OUT_CNT_W-1:0]        sample_count;
	logic                                 overflowed;

	modport source (output valid, std_dev, mean_value, minimum, maximum, sample_count,
		overflowed, input ready);
	modport sink   (input valid, std_dev, mean_value, minimum, maximum, sample_count,
		overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssd_divider.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module ssd_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ssd_pkg::DEV_W-1:0]   dividend,
	input  wire logic [ssd_pkg::CNT_W-1:0]   divisor,
	output logic      [ssd_pkg::DEV_W-1:0]   quotient,
	output logic                             busy,
	output logic                             done
);
	localparam int DW = ssd_pkg::DEV_W;
	localparam int NW = ssd_pkg::CNT_W;

	logic [DW-1:0]                  quo_q;
	logic [NW-1:0]                  rem_q;
	logic [NW-1:0]                  den_q;
	logic [ssd_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [NW:0] trial;
	logic [NW:0] diff;
	logic        fits;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// control: busy and the done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssd_pkg::DIV_CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssd_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// ===== rtl/ssd_sqrt.sv =====
// Iterative integer square root, one root bit (two radicand bits) per cycle.
`default_nettype none
module ssd_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ssd_pkg::RAD_W-1:0]   radicand,
	output logic      [ssd_pkg::ROOT_W-1:0]  root,
	output logic                             busy,
	output logic                             done
);
	localparam int RW = ssd_pkg::RAD_W;
	localparam int TW = ssd_pkg::ROOT_W;
	localparam int EW = TW + 4;   // remainder and trial width

	logic [RW-1:0]                   rad_q;
	logic [TW-1:0]                   root_q;
	logic [EW-3:0]                   rem_q;
	logic [ssd_pkg::SQRT_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [EW-1:0] acc;
	logic [EW-1:0] trial;
	logic [EW-1:0] diff;
	logic          fits;

	// bring down two bits, compare with 4*root+1
	always_comb begin
		acc   = {rem_q, rad_q[RW-1:RW-2]};
		trial = EW'({root_q, 2'b01});
		diff  = acc - trial;
		fits  = acc >= trial;
	end

	// control: busy and the done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssd_pkg::SQRT_CNT_W'(TW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssd_pkg::SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: radicand shift, partial remainder, root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			rem_q  <= fits ? diff[EW-3:0] : acc[EW-3:0];
			root_q <= {root_q[TW-2:0], fits};
		end
	end

	assign root = root_q;
	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/ssd_datapath.sv =====
// Datapath: running accumulators, deviation arithmetic, divider, root and result register.
`default_nettype none
module ssd_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ssd_pkg::ssd_cmd_t                    cmd,
	output ssd_pkg::ssd_stat_t                        stat,
	input  wire logic signed [ssd_pkg::SAMPLE_W-1:0]  sample,
	output logic      [ssd_pkg::ROOT_W-1:0]           std_dev,
	output logic signed [ssd_pkg::SAMPLE_W-1:0]       mean_value,
	output logic signed [ssd_pkg::SAMPLE_W-1:0]       minimum,
	output logic signed [ssd_pkg::SAMPLE_W-1:0]       maximum,
	output logic      [ssd_pkg::OUT_CNT_W-1:0]        sample_count,
	output logic                                      overflowed
);
	localparam int XW = ssd_pkg::SAMPLE_W;

	// running state of the set
	logic signed [ssd_pkg::SUM_W-1:0]    sum_q;
	logic        [ssd_pkg::SQSUM_W-1:0]  sqsum_q;
	logic        [ssd_pkg::CNT_W-1:0]    count_q;
	logic signed [XW-1:0]                min_q;
	logic signed [XW-1:0]                max_q;
	logic                                drop_q;

	// squaring pipeline
	logic signed [XW-1:0]          x_s1;
	logic                          sqv_s1;
	logic [ssd_pkg::SQ_W-1:0]      sq_s2;
	logic                          sqv_s2;
	logic signed [2*XW-1:0]        sq_full;

	// end-of-set arithmetic
	logic signed [ssd_pkg::MEAN_W-1:0]   mean_q;
	logic signed [ssd_pkg::MS_W-1:0]     ms_q;
	logic        [ssd_pkg::MM_W-1:0]     mm_q;
	logic        [ssd_pkg::NMM_W-1:0]    nmm_q;
	logic signed [ssd_pkg::IW-1:0]       d_q;
	logic        [ssd_pkg::DEV_W-1:0]    dev_q;
	logic signed [2*ssd_pkg::MEAN_W-1:0] mm_full;
	logic signed [ssd_pkg::IW-1:0]       dev_sum;
	logic        [ssd_pkg::SUM_W-1:0]    abs_sum;
	logic signed [ssd_pkg::MEAN_W-1:0]   q_mag;
	logic        [ssd_pkg::DEV_W-1:0]    dividend;
	logic        [ssd_pkg::DEV_W-1:0]    quotient;
	logic        [ssd_pkg::ROOT_W-1:0]   root;
	logic        [ssd_pkg::CNT_W+ssd_pkg::OUT_CNT_W-1:0] count_ext;

	logic full;
	logic take;

	// a sample enters the set only while there is room
	assign full = count_q == ssd_pkg::CNT_W'(ssd_pkg::MAX_SAMPLES);
	assign take = cmd.accept && !full;

	// accumulators, cleared when the result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sqsum_q <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			sqv_s1  <= 1'b0;
			sqv_s2  <= 1'b0;
		end else begin
			sqv_s1 <= take;
			sqv_s2 <= sqv_s1;
			if (cmd.out_load) begin
				sum_q   <= '0;
				sqsum_q <= '0;
				count_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				if (cmd.accept && full)
					drop_q <= 1'b1;
				if (take) begin
					sum_q   <= sum_q + ssd_pkg::SUM_W'(sample);
					count_q <= count_q + 1'b1;
				end
				if (sqv_s2)
					sqsum_q <= sqsum_q + ssd_pkg::SQSUM_W'(sq_s2);
			end
		end
	end

	// minimum and maximum, first sample of a set seeds both
	always_ff @(posedge clk) begin
		if (take) begin
			if (count_q == '0 || sample < min_q)
				min_q <= sample;
			if (count_q == '0 || sample > max_q)
				max_q <= sample;
		end
	end

	// square one sample per cycle
	assign sq_full = x_s1 * x_s1;
	always_ff @(posedge clk) begin
		x_s1  <= sample;
		sq_s2 <= sq_full[ssd_pkg::SQ_W-1:0];
	end

	// divider operand select: |sum| for the mean, deviation sum for the variance
	always_comb begin
		abs_sum  = sum_q[ssd_pkg::SUM_W-1] ? ssd_pkg::SUM_W'(-sum_q) : sum_q;
		dividend = cmd.div_sel_var ? dev_q : ssd_pkg::DEV_W'(abs_sum);
		q_mag    = $signed({1'b0, quotient[XW-1:0]});
		mm_full  = mean_q * mean_q;
		dev_sum  = d_q + $signed(ssd_pkg::IW'(nmm_q));
	end

	// sum (x-m)^2 = S2 - 2mS + n*m^2, a register after each multiply
	always_ff @(posedge clk) begin
		if (cmd.mean_load)
			mean_q <= sum_q[ssd_pkg::SUM_W-1] ? -q_mag : q_mag;
		if (cmd.mul1_load) begin
			ms_q <= mean_q * sum_q;
			mm_q <= mm_full[ssd_pkg::MM_W-1:0];
		end
		if (cmd.mul2_load) begin
			nmm_q <= count_q * mm_q;
			d_q   <= $signed(ssd_pkg::IW'(sqsum_q)) - (ssd_pkg::IW'(ms_q) <<< 1);
		end
		if (cmd.dev_load)
			dev_q <= dev_sum[ssd_pkg::IW-1] ? '0 : dev_sum[ssd_pkg::DEV_W-1:0];
	end

	ssd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.quotient (quotient),
		.busy     (stat.div_busy),
		.done     (stat.div_done)
	);

	ssd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (quotient[ssd_pkg::RAD_W-1:0]),
		.root     (root),
		.busy     (stat.sqrt_busy),
		.done     (stat.sqrt_done)
	);

	// result register
	assign count_ext = (ssd_pkg::CNT_W + ssd_pkg::OUT_CNT_W)'(count_q);
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			std_dev      <= root;
			mean_value   <= mean_q[XW-1:0];
			minimum      <= min_q;
			maximum      <= max_q;
			sample_count <= count_ext[ssd_pkg::OUT_CNT_W-1:0];
			overflowed   <= drop_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ssd_ctrl.sv =====
// Controller: sequences accumulation, mean divide, deviation sum, variance divide and root.
`default_nettype none
module ssd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_last,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire ssd_pkg::ssd_stat_t  stat,
	output ssd_pkg::ssd_cmd_t        cmd
);
	typedef enum logic [3:0] {
		ST_ACC,
		ST_PIPE1,
		ST_PIPE2,
		ST_MDIV,
		ST_MEAN,
		ST_MUL1,
		ST_MUL2,
		ST_DEV,
		ST_VDIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   div_start_q;
	logic   sel_var_q;
	logic   mean_load_q;
	logic   mul1_q;
	logic   mul2_q;
	logic   dev_load_q;
	logic   sqrt_start_q;
	logic   fire;
	logic   out_free;

	assign fire     = in_valid && ready_q;
	assign out_free = !out_valid_q || out_ready;

	// state and registered command pulses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_ACC;
			ready_q      <= 1'b1;
			out_valid_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sel_var_q    <= 1'b0;
			mean_load_q  <= 1'b0;
			mul1_q       <= 1'b0;
			mul2_q       <= 1'b0;
			dev_load_q   <= 1'b0;
			sqrt_start_q <= 1'b0;
		end else begin
			div_start_q  <= 1'b0;
			mean_load_q  <= 1'b0;
			mul1_q       <= 1'b0;
			mul2_q       <= 1'b0;
			dev_load_q   <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (fire && in_last) begin
						ready_q <= 1'b0;
						state_q <= ST_PIPE1;
					end
				end
				// let the last square reach the sum
				ST_PIPE1: state_q <= ST_PIPE2;
				ST_PIPE2: begin
					div_start_q <= 1'b1;
					sel_var_q   <= 1'b0;
					state_q     <= ST_MDIV;
				end
				ST_MDIV: begin
					if (stat.div_done) begin
						mean_load_q <= 1'b1;
						state_q     <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					mul1_q  <= 1'b1;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					mul2_q  <= 1'b1;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					dev_load_q <= 1'b1;
					state_q    <= ST_DEV;
				end
				ST_DEV: begin
					div_start_q <= 1'b1;
					sel_var_q   <= 1'b1;
					state_q     <= ST_VDIV;
				end
				ST_VDIV: begin
					if (stat.div_done) begin
						sqrt_start_q <= 1'b1;
						state_q      <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (stat.sqrt_done)
						state_q <= ST_OUT;
				end
				// wait for the result register to be free
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ready_q     <= 1'b1;
						state_q     <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// command bundle
	always_comb begin
		cmd.accept      = fire;
		cmd.div_start   = div_start_q;
		cmd.div_sel_var = sel_var_q;
		cmd.mean_load   = mean_load_q;
		cmd.mul1_load   = mul1_q;
		cmd.mul2_load   = mul2_q;
		cmd.dev_load    = dev_load_q;
		cmd.sqrt_start  = sqrt_start_q;
		cmd.out_load    = (state_q == ST_OUT) && out_free;
	end

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== rtl/sample_set_std_deviation.sv =====
// Top level: statistics (count, min, max, mean, standard deviation) over a sample set.
// Throughput: one sample per cycle while a set streams in; ready drops after the last one.
// After the last sample transfer the result is produced by the bit-serial divider used twice
//   (mean, variance) and the 16-step root.
// A new set is taken once its predecessor's result is in the output register.
// Reset (arst_n low, asynchronous) clears the accumulators, the sequencer and the output valid.
`default_nettype none
module sample_set_std_deviation (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssd_in_if.sink     samples,
	ssd_out_if.source  results
);
	ssd_pkg::ssd_cmd_t  cmd;
	ssd_pkg::ssd_stat_t stat;

	ssd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last_sample),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (samples.sample),
		.std_dev      (results.std_dev),
		.mean_value   (results.mean_value),
		.minimum      (results.minimum),
		.maximum      (results.maximum),
		.sample_count (results.sample_count),
		.overflowed   (results.overflowed)
	);

	// the last sample of a set closes the input
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.last_sample) |=> !samples.ready)
		else $error("input still open after the last sample");

	// divider and root never run together, and neither runs while samples stream
	a_units_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.div_busy && stat.sqrt_busy))
		else $error("divider and root busy at once");

	a_idle_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> (!stat.div_busy && !stat.sqrt_busy))
		else $error("arithmetic unit busy while accepting samples");

	// a reported mean lies between the reported extremes
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.minimum <= results.mean_value &&
			results.mean_value <= results.maximum))
		else $error("mean outside the min/max range");
endmodule
`default_nettype wire
